/* rtl/core/format_string_text_formatter_unit_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the text formatter
// ---------------------------------------------------------------------------
`ifndef FORMAT_STRING_TEXT_FORMATTER_UNIT_MACROS_SVH
`define FORMAT_STRING_TEXT_FORMATTER_UNIT_MACROS_SVH

// Implication checked every clock edge, masked during reset.
`define FSTF_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define FSTF_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* rtl/core/fstf_pkg.sv */
// ---------------------------------------------------------------------------
// fstf_pkg
// Types and constants shared by the text formatter modules.
// ---------------------------------------------------------------------------
package fstf_pkg;

    localparam int LONG_BITS_DEF = 64;
    localparam int MAX_WIDTH_DEF = 64;

    localparam logic [1:0] OP_FMT  = 2'd0;
    localparam logic [1:0] OP_NUM  = 2'd1;
    localparam logic [1:0] OP_STR  = 2'd2;
    localparam logic [1:0] OP_NULL = 2'd3;

    localparam logic [2:0] CV_NONE = 3'd0;
    localparam logic [2:0] CV_C    = 3'd1;
    localparam logic [2:0] CV_LX   = 3'd2;
    localparam logic [2:0] CV_UX   = 3'd3;
    localparam logic [2:0] CV_P    = 3'd4;
    localparam logic [2:0] CV_D    = 3'd5;
    localparam logic [2:0] CV_U    = 3'd6;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  format_char;
        logic [63:0] arg_word;
    } t_in_item;

    typedef struct packed {
        logic [7:0] text_char;
        logic       run_last;
        logic       sequence_error;
    } t_out_item;

    // Job handed from the parser to the number unit.
    typedef struct packed {
        logic [63:0] value;
        logic        dec;
        logic        upper;
        logic        zpad;
        logic [6:0]  width;
        logic        neg;
        logic        pfx;
    } t_num_job;

    function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10) c = 8'h30 + {4'd0, d};
        else if (upper) c = 8'h41 + {4'd0, d} - 8'd10;
        else c = 8'h61 + {4'd0, d} - 8'd10;
        return c;
    endfunction

endpackage

/* rtl/core/fstf_num.sv */
// ---------------------------------------------------------------------------
// fstf_num
// Digit-serial number emitter: decimal by shift-subtract, hex by nibbles.
// ---------------------------------------------------------------------------
module fstf_num #(
    parameter int MAX_WIDTH = fstf_pkg::MAX_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  fstf_pkg::t_num_job i_job,
    output logic               o_busy,
    output logic               o_valid,
    output logic [7:0]         o_char,
    output logic               o_last,
    input  logic               i_take
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_PRE  = 3'd2;
    localparam logic [2:0] S_PAD  = 3'd3;
    localparam logic [2:0] S_DIG  = 3'd4;

    logic [2:0]  r_st, n_st;
    logic [63:0] r_q, n_q;
    logic [3:0]  r_rem, n_rem;
    logic [6:0]  r_bit, n_bit;
    logic [79:0] r_dig, n_dig;     // digit stack, nibble per digit, top at [3:0]
    logic [4:0]  r_nd, n_nd;
    logic [6:0]  r_pad, n_pad;
    logic [1:0]  r_pre, n_pre;     // prefix chars left: '-' or "0x"
    logic        r_pfx, n_pfx;
    logic        r_dec, n_dec;
    logic        r_up, n_up;
    logic        r_zp, n_zp;

    logic [4:0] w_tr;
    logic [3:0] w_rs;

    always_comb begin
        n_st = r_st; n_q = r_q; n_rem = r_rem; n_bit = r_bit; n_dig = r_dig;
        n_nd = r_nd; n_pad = r_pad; n_pre = r_pre; n_pfx = r_pfx; n_dec = r_dec;
        n_up = r_up; n_zp = r_zp;
        w_tr = {r_rem, r_q[63]};
        w_rs = (w_tr >= 5'd10) ? 4'(w_tr - 5'd10) : w_tr[3:0];
        o_valid = 1'b0; o_char = 8'h00; o_last = 1'b0;
        unique case (r_st)
            S_IDLE: begin
                if (i_start) begin
                    n_q = i_job.value; n_dec = i_job.dec; n_up = i_job.upper;
                    n_zp = i_job.zpad; n_pad = i_job.width; n_rem = 4'd0;
                    n_bit = 7'd0; n_nd = 5'd0; n_dig = '0;
                    n_pfx = i_job.pfx;
                    n_pre = i_job.pfx ? 2'd2 : (i_job.neg ? 2'd1 : 2'd0);
                    n_st = S_DIV;
                end
            end
            S_DIV: begin
                if (r_dec) begin
                    // one quotient bit per cycle
                    n_q = {r_q[62:0], w_tr >= 5'd10};
                    n_rem = w_rs;
                    n_bit = r_bit + 7'd1;
                    if (r_bit == 7'd63) begin
                        n_dig = {r_dig[75:0], w_rs};
                        n_nd = r_nd + 5'd1;
                        n_rem = 4'd0; n_bit = 7'd0;
                        if ({r_q[62:0], w_tr >= 5'd10} == 64'd0) n_st = S_PRE;
                    end
                end else begin
                    n_dig = {r_dig[75:0], r_q[3:0]};
                    n_nd = r_nd + 5'd1;
                    n_q = {4'd0, r_q[63:4]};
                    if (r_q[63:4] == 60'd0) n_st = S_PRE;
                end
                if (n_st == S_PRE)
                    n_pad = (r_pad > {2'd0, n_nd}) ? r_pad - {2'd0, n_nd} : 7'd0;
            end
            S_PRE: begin
                if (r_pre == 2'd0) n_st = (r_pad != 7'd0) ? S_PAD : S_DIG;
                else begin
                    o_valid = 1'b1;
                    o_char = (!r_pfx) ? 8'h2d : (r_pre == 2'd2 ? 8'h30 : 8'h78);
                    if (i_take) n_pre = r_pre - 2'd1;
                end
            end
            S_PAD: begin
                o_valid = 1'b1;
                o_char = r_zp ? 8'h30 : 8'h20;
                if (i_take) begin
                    n_pad = r_pad - 7'd1;
                    if (r_pad == 7'd1) n_st = S_DIG;
                end
            end
            S_DIG: begin
                o_valid = 1'b1;
                o_char = fstf_pkg::hex_char(r_dig[3:0], r_up);
                o_last = (r_nd == 5'd1);
                if (i_take) begin
                    n_dig = {4'd0, r_dig[79:4]};
                    n_nd = r_nd - 5'd1;
                    if (r_nd == 5'd1) n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    assign o_busy = (r_st != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= S_IDLE;
        else          r_st <= n_st;
        r_q <= n_q; r_rem <= n_rem; r_bit <= n_bit; r_dig <= n_dig; r_nd <= n_nd;
        r_pad <= n_pad; r_pre <= n_pre; r_pfx <= n_pfx; r_dec <= n_dec;
        r_up <= n_up; r_zp <= n_zp;
    end

    `include "format_string_text_formatter_unit_macros.svh"
    `FSTF_ASSERT_IMP(a_no_start_busy, i_clk, i_rst_n, o_busy, !i_start, "start while busy")
    `FSTF_ASSERT_IMP(a_width_cap, i_clk, i_rst_n, i_start, i_job.width <= 7'(MAX_WIDTH), "width over cap")
    `FSTF_ASSERT_IMP(a_dig_count, i_clk, i_rst_n, r_st == S_DIG, r_nd != 5'd0 && r_nd <= 5'd20, "digit count")
endmodule

/* rtl/core/format_string_text_formatter_unit.sv */
// ---------------------------------------------------------------------------
// format_string_text_formatter_unit
// printf-style formatter: format bytes and arguments in, text bytes out.
// ---------------------------------------------------------------------------
// One item at a time. o_ready drops from the accepting edge until the last
// character caused by the beat has been loaded into the output register;
// a beat that causes no character leaves o_ready high. A format or string
// beat holds the input while its queued characters go out. A hex or pointer
// argument is accepted, its significant nibbles are stacked, then the output
// characters follow. A decimal argument runs a bit-serial divide by ten per
// digit (up to 20 digits), then its output characters follow. A receiver
// stall holds the emitter as well. No reset sweep.
module format_string_text_formatter_unit #(
    parameter int LONG_BITS = fstf_pkg::LONG_BITS_DEF,
    parameter int MAX_WIDTH = fstf_pkg::MAX_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  fstf_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output fstf_pkg::t_out_item o_data
);
    localparam logic [2:0] PH_LIT = 3'd0, PH_PCT = 3'd1, PH_WID = 3'd2, PH_CNV = 3'd3,
                           PH_ARG = 3'd4, PH_STR = 3'd5, PH_STRM = 3'd6;
    localparam logic [1:0] E_IDLE = 2'd0, E_Q = 2'd1, E_NUM = 2'd2;
    localparam logic [6:0] WCAP = 7'(MAX_WIDTH);
    localparam logic [63:0] LMASK = (LONG_BITS == 64) ? '1 : ((64'd1 << LONG_BITS) - 64'd1);

    logic [2:0]  r_ph, n_ph;
    logic        r_zp, n_zp;
    logic [6:0]  r_w, n_w;
    logic        r_l, n_l;
    logic [2:0]  r_cv, n_cv;
    logic [1:0]  r_em, n_em;
    logic [47:0] r_qc, n_qc;       // queued literal chars, next at [7:0]
    logic [2:0]  r_qn, n_qn;
    logic        r_qerr, n_qerr;
    logic        r_ov, n_ov;
    fstf_pkg::t_out_item r_od, n_od;

    logic               w_start, w_nv, w_nl, w_nbusy, w_take, w_ok, w_acc;
    logic [7:0]         w_nc;
    fstf_pkg::t_num_job w_job;
    logic [7:0]         b;
    logic [1:0]         op;
    logic [63:0]        w_v, w_sb, w_mask;
    logic [10:0]        w_wid;

    assign op = i_data.opcode;
    assign b = i_data.format_char;
    assign o_ready = (r_em == E_IDLE) && !w_nbusy;
    assign w_acc = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_data = r_od;
    assign w_take = !r_ov || i_ready;

    fstf_num #(.MAX_WIDTH(MAX_WIDTH)) u_num (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_job(w_job),
        .o_busy(w_nbusy), .o_valid(w_nv), .o_char(w_nc), .o_last(w_nl),
        .i_take(w_take && r_em == E_NUM)
    );

    always_comb begin
        n_ph = r_ph; n_zp = r_zp; n_w = r_w; n_l = r_l; n_cv = r_cv; n_em = r_em;
        n_qc = r_qc; n_qn = r_qn; n_qerr = r_qerr; n_ov = r_ov; n_od = r_od;
        w_start = 1'b0;
        w_mask = r_l ? LMASK : 64'h0000_0000_FFFF_FFFF;
        w_sb = r_l ? (64'd1 << (LONG_BITS - 1)) : 64'h0000_0000_8000_0000;
        w_v = i_data.arg_word & w_mask;
        w_wid = {1'b0, r_w, 3'b0} + {3'b0, r_w, 1'b0} + {3'd0, b - 8'h30};
        w_job = '{value: w_v, dec: 1'b1, upper: 1'b0, zpad: 1'b0, width: 7'd0,
                  neg: 1'b0, pfx: 1'b0};
        if (r_ov && i_ready) n_ov = 1'b0;
        unique case (r_ph)
            PH_LIT, PH_PCT, PH_WID, PH_CNV: w_ok = (op == fstf_pkg::OP_FMT);
            PH_ARG:  w_ok = (op == fstf_pkg::OP_NUM);
            PH_STR:  w_ok = (op == fstf_pkg::OP_STR) || (op == fstf_pkg::OP_NULL);
            PH_STRM: w_ok = (op == fstf_pkg::OP_STR);
            default: w_ok = 1'b0;
        endcase
        if (w_acc) begin
            n_qn = 3'd0; n_qc = '0; n_qerr = 1'b0; n_em = E_Q;
            if (!w_ok) begin
                if (r_ph > PH_STRM) begin
                    n_ph = PH_LIT; n_zp = 1'b0; n_w = 7'd0; n_l = 1'b0; n_cv = fstf_pkg::CV_NONE;
                end
                n_qn = 3'd1; n_qerr = 1'b1;
            end else if (op == fstf_pkg::OP_FMT) begin
                if (b == 8'h00) begin
                    n_ph = PH_LIT; n_zp = 1'b0; n_w = 7'd0; n_l = 1'b0; n_cv = fstf_pkg::CV_NONE;
                end else if (r_ph == PH_LIT) begin
                    if (b == 8'h25) begin
                        n_ph = PH_PCT; n_zp = 1'b0; n_w = 7'd0; n_l = 1'b0;
                        n_cv = fstf_pkg::CV_NONE;
                    end else begin
                        n_qc[7:0] = b; n_qn = 3'd1;
                    end
                end else if (r_ph == PH_PCT && b == 8'h30) begin
                    n_zp = 1'b1; n_ph = PH_WID;
                end else if ((r_ph == PH_PCT || r_ph == PH_WID) && b >= 8'h30 && b <= 8'h39) begin
                    n_w = (w_wid > {4'd0, WCAP}) ? WCAP : w_wid[6:0];
                    n_ph = PH_WID;
                end else if ((r_ph == PH_PCT || r_ph == PH_WID) && b == 8'h6c) begin
                    n_l = 1'b1; n_ph = PH_CNV;
                end else begin
                    n_ph = PH_ARG;
                    unique case (b)
                        8'h63: n_cv = fstf_pkg::CV_C;
                        8'h78: n_cv = fstf_pkg::CV_LX;
                        8'h58: n_cv = fstf_pkg::CV_UX;
                        8'h70: n_cv = fstf_pkg::CV_P;
                        8'h64: n_cv = fstf_pkg::CV_D;
                        8'h75: n_cv = fstf_pkg::CV_U;
                        8'h73: begin n_cv = fstf_pkg::CV_NONE; n_ph = PH_STR; end
                        8'h25: begin n_ph = PH_LIT; n_qc[7:0] = 8'h25; n_qn = 3'd1; end
                        default: begin
                            n_ph = PH_LIT;
                            if (r_l) begin n_qc[23:0] = {b, 8'h6c, 8'h25}; n_qn = 3'd3; end
                            else     begin n_qc[15:0] = {b, 8'h25};        n_qn = 3'd2; end
                        end
                    endcase
                    if (n_ph == PH_LIT) begin
                        n_zp = 1'b0; n_w = 7'd0; n_l = 1'b0; n_cv = fstf_pkg::CV_NONE;
                    end
                end
            end else if (op == fstf_pkg::OP_NUM) begin
                n_ph = PH_LIT; n_zp = 1'b0; n_w = 7'd0; n_l = 1'b0; n_cv = fstf_pkg::CV_NONE;
                unique case (r_cv)
                    fstf_pkg::CV_C: begin n_qc[7:0] = i_data.arg_word[7:0]; n_qn = 3'd1; end
                    fstf_pkg::CV_LX, fstf_pkg::CV_UX: begin
                        w_job.dec = 1'b0; w_job.upper = (r_cv == fstf_pkg::CV_UX);
                        w_job.zpad = r_zp; w_job.width = r_w;
                        w_start = 1'b1; n_em = E_NUM;
                    end
                    fstf_pkg::CV_P: begin
                        w_job.dec = 1'b0; w_job.pfx = 1'b1;
                        w_job.value = {32'd0, i_data.arg_word[31:0]};
                        w_start = 1'b1; n_em = E_NUM;
                    end
                    fstf_pkg::CV_D: begin
                        if ((w_v & w_sb) != 64'd0) begin
                            w_job.neg = 1'b1;
                            w_job.value = (~w_v + 64'd1) & w_mask;
                            if (w_job.value == 64'd0) w_job.value = w_sb;
                        end
                        w_start = 1'b1; n_em = E_NUM;
                    end
                    default: begin w_start = 1'b1; n_em = E_NUM; end
                endcase
            end else if (op == fstf_pkg::OP_NULL) begin
                n_qc = {8'h29, 8'h6c, 8'h6c, 8'h75, 8'h6e, 8'h28}; n_qn = 3'd6;
                n_ph = PH_LIT; n_zp = 1'b0; n_w = 7'd0; n_l = 1'b0; n_cv = fstf_pkg::CV_NONE;
            end else begin
                if (b == 8'h00) begin
                    n_ph = PH_LIT; n_zp = 1'b0; n_w = 7'd0; n_l = 1'b0; n_cv = fstf_pkg::CV_NONE;
                end else begin
                    n_qc[7:0] = b; n_qn = 3'd1; n_ph = PH_STRM;
                end
            end
            if (n_em == E_Q && n_qn == 3'd0) n_em = E_IDLE;
        end else if (r_em == E_Q) begin
            if (w_take) begin
                n_ov = 1'b1;
                n_od = '{text_char: r_qc[7:0], run_last: (r_qn == 3'd1),
                         sequence_error: r_qerr};
                n_qc = {8'd0, r_qc[47:8]};
                n_qn = r_qn - 3'd1;
                if (r_qn == 3'd1) n_em = E_IDLE;
            end
        end else if (r_em == E_NUM) begin
            if (w_take && w_nv) begin
                n_ov = 1'b1;
                n_od = '{text_char: w_nc, run_last: w_nl, sequence_error: 1'b0};
                if (w_nl) n_em = E_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_LIT; r_zp <= 1'b0; r_w <= 7'd0; r_l <= 1'b0;
            r_cv <= fstf_pkg::CV_NONE; r_em <= E_IDLE; r_ov <= 1'b0; r_qn <= 3'd0;
        end else begin
            r_ph <= n_ph; r_zp <= n_zp; r_w <= n_w; r_l <= n_l;
            r_cv <= n_cv; r_em <= n_em; r_ov <= n_ov; r_qn <= n_qn;
        end
        r_qc <= n_qc; r_qerr <= n_qerr; r_od <= n_od;
    end

    `include "format_string_text_formatter_unit_macros.svh"
    `FSTF_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, r_em == E_IDLE && !w_nbusy, "ready while busy")
    `FSTF_ASSERT_IMP(a_width_sat, i_clk, i_rst_n, 1'b1, r_w <= WCAP, "width over cap")
    `FSTF_ASSERT_NXT(a_num_start, i_clk, i_rst_n, w_start, r_em == E_NUM, "number job lost")
    `FSTF_ASSERT_IMP(a_err_single, i_clk, i_rst_n, r_ov && r_od.sequence_error, r_od.run_last, "error beat not last")
endmodule
